### sv/mfts_pkg.sv
package mfts_pkg;

	localparam int FIELD_W = 11;
	localparam logic [FIELD_W-1:0] NODE_COUNT_RST = 11'd1024;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [FIELD_W-1:0] edge_from;
		logic [FIELD_W-1:0] edge_to;
	} item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] record_count;
		logic [FIELD_W-1:0] emitted_count;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_EDGE_WR,
		ST_SCAN,
		ST_SCAN_END,
		ST_POP_CHK,
		ST_POP_TOP,
		ST_POP_LAST,
		ST_SD_CHK,
		ST_SD_LEFT,
		ST_SD_RIGHT,
		ST_SD_CMP,
		ST_EMIT,
		ST_HEAD,
		ST_WALK,
		ST_LINK,
		ST_DEG,
		ST_SU_CHK,
		ST_SU_CMP,
		ST_DONE,
		ST_CLEAR
	} state_t;

endpackage

### sv/mfts_ram.sv
module mfts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/mfts_engine.sv
module mfts_engine #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_EDGES = 4096
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  mfts_pkg::item_t          item,
	input  logic [mfts_pkg::FIELD_W-1:0] node_count,
	output mfts_pkg::eng_stat_t      stat,
	output mfts_pkg::result_t        res
);
	import mfts_pkg::*;

	localparam int VW  = $clog2(MAX_NODES + 1);
	localparam int AW  = $clog2(MAX_NODES);
	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam int EAW = $clog2(MAX_EDGES);

	state_t state_q, state_d;

	logic [VW-1:0]  n;
	logic [VW-1:0]  v_q, scan_v_s1, size_q, top_q, last_q, cval_q, t_q;
	logic [VW-1:0]  max_q, rec_q, emit_q, from_q, to_q;
	logic           scan_vld_s1, drop_q;
	logic [AW-1:0]  i_q, c_q, clr_q;
	logic [EW-1:0]  e_q, edge_cnt_q;
	logic           edge_ok, t_ok, scan_push;
	int             c_w;

	logic           hd_we, dg_we, nx_we, tg_we, hp_we;
	logic [AW-1:0]  hd_waddr, hd_raddr, dg_waddr, dg_raddr, hp_waddr, hp_raddr;
	logic [EAW-1:0] nx_waddr, nx_raddr, tg_waddr, tg_raddr;
	logic [EW-1:0]  hd_wdata, hd_rdata, dg_wdata, dg_rdata, nx_wdata, nx_rdata;
	logic [VW-1:0]  tg_wdata, tg_rdata, hp_wdata, hp_rdata;

	mfts_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_head (
		.clk(clk), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
		.raddr(hd_raddr), .rdata(hd_rdata)
	);
	mfts_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_deg (
		.clk(clk), .we(dg_we), .waddr(dg_waddr), .wdata(dg_wdata),
		.raddr(dg_raddr), .rdata(dg_rdata)
	);
	mfts_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.raddr(nx_raddr), .rdata(nx_rdata)
	);
	mfts_ram #(.WIDTH(VW), .DEPTH(MAX_EDGES)) u_target (
		.clk(clk), .we(tg_we), .waddr(tg_waddr), .wdata(tg_wdata),
		.raddr(tg_raddr), .rdata(tg_rdata)
	);
	mfts_ram #(.WIDTH(VW), .DEPTH(MAX_NODES)) u_heap (
		.clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
		.raddr(hp_raddr), .rdata(hp_rdata)
	);

	always_comb begin
		if (32'(node_count) > MAX_NODES) begin
			n = VW'(MAX_NODES);
		end else begin
			n = VW'(node_count);
		end
	end

	assign edge_ok = (item.edge_from != '0) && (32'(item.edge_from) <= 32'(n)) &&
		(item.edge_to != '0) && (32'(item.edge_to) <= 32'(n)) &&
		(32'(edge_cnt_q) < MAX_EDGES);
	assign t_ok = (tg_rdata != '0) && (32'(tg_rdata) <= 32'(n));
	assign c_w = 32'(i_q) * 2 + 1;
	assign scan_push = ((state_q == ST_SCAN) || (state_q == ST_SCAN_END)) &&
		scan_vld_s1 && (dg_rdata == '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (item.opcode == OP_RUN) begin
						state_d = (n == '0) ? ST_DONE : ST_SCAN;
					end else if (edge_ok) begin
						state_d = ST_EDGE_WR;
					end
				end
			end
			ST_EDGE_WR:  state_d = ST_IDLE;
			ST_SCAN:     state_d = (v_q == n) ? ST_SCAN_END : ST_SCAN;
			ST_SCAN_END: state_d = ST_POP_CHK;
			ST_POP_CHK:  state_d = (size_q == '0) ? ST_DONE : ST_POP_TOP;
			ST_POP_TOP:  state_d = ST_POP_LAST;
			ST_POP_LAST: state_d = ST_SD_CHK;
			ST_SD_CHK:   state_d = (c_w >= 32'(size_q)) ? ST_EMIT : ST_SD_LEFT;
			ST_SD_LEFT:  state_d = (32'(c_q) + 1 < 32'(size_q)) ? ST_SD_RIGHT : ST_SD_CMP;
			ST_SD_RIGHT: state_d = ST_SD_CMP;
			ST_SD_CMP:   state_d = (cval_q >= last_q) ? ST_EMIT : ST_SD_CHK;
			ST_EMIT:     state_d = ST_HEAD;
			ST_HEAD:     state_d = ST_WALK;
			ST_WALK:     state_d = (e_q == '0) ? ST_POP_CHK : ST_LINK;
			ST_LINK:     state_d = t_ok ? ST_DEG : ST_WALK;
			ST_DEG:      state_d = (dg_rdata == EW'(1)) ? ST_SU_CHK : ST_WALK;
			ST_SU_CHK:   state_d = (i_q == '0) ? ST_WALK : ST_SU_CMP;
			ST_SU_CMP:   state_d = (hp_rdata <= t_q) ? ST_WALK : ST_SU_CHK;
			ST_DONE:     state_d = ST_CLEAR;
			ST_CLEAR:    state_d = (32'(clr_q) == MAX_NODES - 1) ? ST_IDLE : ST_CLEAR;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Memory controls.
	always_comb begin
		hd_we = 1'b0; hd_waddr = '0; hd_wdata = '0; hd_raddr = '0;
		dg_we = 1'b0; dg_waddr = '0; dg_wdata = '0; dg_raddr = '0;
		nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_raddr = '0;
		tg_we = 1'b0; tg_waddr = '0; tg_wdata = '0; tg_raddr = '0;
		hp_we = 1'b0; hp_waddr = '0; hp_wdata = '0; hp_raddr = '0;
		case (state_q)
			ST_IDLE: begin
				hd_raddr = AW'(32'(item.edge_from) - 1);
				dg_raddr = AW'(32'(item.edge_to) - 1);
			end
			ST_EDGE_WR: begin
				hd_we    = 1'b1;
				hd_waddr = AW'(32'(from_q) - 1);
				hd_wdata = edge_cnt_q;
				nx_we    = 1'b1;
				nx_waddr = EAW'(32'(edge_cnt_q) - 1);
				nx_wdata = hd_rdata;
				tg_we    = 1'b1;
				tg_waddr = EAW'(32'(edge_cnt_q) - 1);
				tg_wdata = to_q;
				dg_we    = 1'b1;
				dg_waddr = AW'(32'(to_q) - 1);
				dg_wdata = dg_rdata + EW'(1);
			end
			ST_SCAN, ST_SCAN_END: begin
				dg_raddr = AW'(32'(v_q) - 1);
				// Vertices arrive in rising order, so appending keeps the heap valid.
				hp_we    = scan_push;
				hp_waddr = AW'(size_q);
				hp_wdata = scan_v_s1;
			end
			ST_POP_TOP: hp_raddr = AW'(32'(size_q) - 1);
			ST_SD_CHK: begin
				if (c_w >= 32'(size_q)) begin
					hp_we    = 1'b1;
					hp_waddr = i_q;
					hp_wdata = last_q;
				end else begin
					hp_raddr = AW'(c_w);
				end
			end
			ST_SD_LEFT: hp_raddr = AW'(32'(c_q) + 1);
			ST_SD_CMP: begin
				hp_we    = 1'b1;
				hp_waddr = i_q;
				hp_wdata = (cval_q >= last_q) ? last_q : cval_q;
			end
			ST_EMIT: hd_raddr = AW'(32'(top_q) - 1);
			ST_WALK: begin
				nx_raddr = EAW'(32'(e_q) - 1);
				tg_raddr = EAW'(32'(e_q) - 1);
			end
			ST_LINK: dg_raddr = AW'(32'(tg_rdata) - 1);
			ST_DEG: begin
				dg_we    = (dg_rdata != '0);
				dg_waddr = AW'(32'(t_q) - 1);
				dg_wdata = dg_rdata - EW'(1);
			end
			ST_SU_CHK: begin
				if (i_q == '0) begin
					hp_we    = 1'b1;
					hp_waddr = '0;
					hp_wdata = t_q;
				end else begin
					hp_raddr = AW'((32'(i_q) - 1) >> 1);
				end
			end
			ST_SU_CMP: begin
				hp_we    = 1'b1;
				hp_waddr = i_q;
				hp_wdata = (hp_rdata <= t_q) ? t_q : hp_rdata;
			end
			ST_CLEAR: begin
				hd_we    = 1'b1;
				hd_waddr = clr_q;
				dg_we    = 1'b1;
				dg_waddr = clr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			edge_cnt_q  <= '0;
			drop_q      <= 1'b0;
			size_q      <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= (state_q == ST_SCAN);
			if (scan_push) begin
				size_q <= size_q + VW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (item.opcode == OP_RUN) begin
							size_q <= '0;
						end else if (edge_ok) begin
							edge_cnt_q <= edge_cnt_q + EW'(1);
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				ST_POP_TOP: size_q <= size_q - VW'(1);
				ST_DEG: begin
					if (dg_rdata == EW'(1)) begin
						size_q <= size_q + VW'(1);
					end
				end
				ST_DONE: begin
					edge_cnt_q <= '0;
					drop_q     <= 1'b0;
					clr_q      <= '0;
				end
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		scan_v_s1 <= v_q;
		case (state_q)
			ST_IDLE: begin
				from_q <= VW'(item.edge_from);
				to_q   <= VW'(item.edge_to);
				v_q    <= VW'(1);
				max_q  <= '0;
				rec_q  <= '0;
				emit_q <= '0;
			end
			ST_SCAN:     v_q <= v_q + VW'(1);
			ST_POP_TOP:  top_q <= hp_rdata;
			ST_POP_LAST: begin
				last_q <= hp_rdata;
				i_q    <= '0;
			end
			ST_SD_CHK:  c_q <= AW'(c_w);
			ST_SD_LEFT: cval_q <= hp_rdata;
			ST_SD_RIGHT: begin
				if (hp_rdata < cval_q) begin
					cval_q <= hp_rdata;
					c_q    <= c_q + AW'(1);
				end
			end
			ST_SD_CMP: begin
				if (cval_q < last_q) begin
					i_q <= c_q;
				end
			end
			ST_EMIT: begin
				emit_q <= emit_q + VW'(1);
				if (top_q > max_q) begin
					rec_q <= rec_q + VW'(1);
					max_q <= top_q;
				end
			end
			ST_HEAD: e_q <= hd_rdata;
			ST_LINK: begin
				e_q <= nx_rdata;
				t_q <= tg_rdata;
			end
			ST_DEG: i_q <= AW'(size_q);
			ST_SU_CHK: c_q <= AW'((32'(i_q) - 1) >> 1);
			ST_SU_CMP: begin
				if (hp_rdata > t_q) begin
					i_q <= c_q;
				end
			end
			default: begin
			end
		endcase
	end

	logic [31:0] rec_w, emit_w;
	assign rec_w  = 32'(rec_q);
	assign emit_w = 32'(emit_q);

	assign stat.busy         = (state_q != ST_IDLE);
	assign stat.done         = (state_q == ST_DONE);
	assign res.record_count  = rec_w[FIELD_W-1:0];
	assign res.emitted_count = emit_w[FIELD_W-1:0];
	assign res.overflow      = drop_q;

endmodule

### sv/min_first_topological_sort_core.sv
// Minimum-first topological sort. Edge beats load a graph into adjacency lists and in-degree
// counters held in block RAM. A run beat sorts the loaded graph, always taking the smallest
// ready vertex from a heap in RAM, and returns one result beat with the record count, the
// emitted count and the overflow flag. A run first seeds the heap with every vertex of zero
// in-degree, then for each vertex pops the heap top, sifts the last entry down and walks its
// outgoing edges; an edge whose target lies above node_count is skipped, and a target that
// becomes ready is sifted up into the heap. Each RAM has a single read port. After each result,
// and after reset, the block clears the list heads and in-degree counters before it takes the
// next beat.
module min_first_topological_sort_core #(
	parameter int MAX_NODES = 1024,
	parameter int MAX_EDGES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  mfts_pkg::item_t               item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output mfts_pkg::result_t             result,
	input  logic                          node_count_we,
	input  logic [mfts_pkg::FIELD_W-1:0]  node_count_wdata
);
	import mfts_pkg::*;

	logic [FIELD_W-1:0] node_count_q;
	logic               result_valid_q;
	result_t            result_q;
	eng_stat_t          eng_stat;
	result_t            eng_res;
	logic               accept;

	// A run waits until the previous result beat has left.
	assign item_stall = eng_stat.busy || (result_valid_q && (item.opcode == OP_RUN));
	assign accept     = item_valid && !item_stall;

	mfts_engine #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_engine (
		.clk(clk), .arst_n(arst_n), .start(accept), .item(item),
		.node_count(node_count_q), .stat(eng_stat), .res(eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q   <= NODE_COUNT_RST;
			result_valid_q <= 1'b0;
		end else begin
			if (node_count_we) begin
				node_count_q <= node_count_wdata;
			end
			if (eng_stat.done) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eng_stat.done) begin
			result_q <= eng_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_done_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.done |-> !(result_valid_q && result_stall))
		else $error("result produced while the output register still holds a beat");

	a_run_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (item.opcode == OP_RUN)) |=> eng_stat.busy)
		else $error("run beat accepted but engine did not start");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		eng_stat.done |=> !eng_stat.done)
		else $error("engine completion held for more than one cycle");

endmodule
